// ===== src/mac_pkg.sv =====
// Shared types and constants for the moving average crossover block.
// Used by the front end, the back end, the top level and the checker.
// No dependencies.
package mac_pkg;

   localparam int MAX_WINDOW_DEF = 1024;
   localparam int PRICE_BITS_DEF = 24;
   localparam int WIN_BITS = 11;
   localparam int CSR_ADDR_BITS = 2;
   localparam int IN_USER_BITS = 2;
   localparam int OUT_USER_BITS = 5;

   localparam logic [WIN_BITS-1:0] SHORT_WINDOW_RST = 11'd10;
   localparam logic [WIN_BITS-1:0] LONG_WINDOW_RST = 11'd20;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_SHORT_WINDOW = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_LONG_WINDOW = 2'd1;

   localparam logic [1:0] CROSS_NONE = 2'd0;
   localparam logic [1:0] CROSS_UP = 2'd1;
   localparam logic [1:0] CROSS_DOWN = 2'd2;

   typedef enum logic {
      OP_SAMPLE,
      OP_DROP
   } op_type;

   typedef struct packed {
      op_type op;
      logic   clear;
   } cmd_ctrl_type;

endpackage

// ===== src/mac_divider.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module mac_divider #(
   parameter int DVD_BITS = 48,
   parameter int DVS_BITS = 25
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DVD_BITS-1:0] dividend,
   input  logic [DVS_BITS-1:0] divisor,
   output logic                done,
   output logic [DVD_BITS-1:0] quotient
);

   localparam int CNT_BITS = $clog2(DVD_BITS + 1);

   logic [DVS_BITS-1:0] rem_ff, rem_in;
   logic [DVD_BITS-1:0] quo_ff;
   logic [DVS_BITS-1:0] dvs_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic                busy_ff;
   logic                done_ff;
   logic [DVS_BITS:0]   shifted;
   logic [DVS_BITS:0]   diff;
   logic                ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[DVD_BITS-1]};
      diff = shifted - {1'b0, dvs_ff};
      ge = shifted >= {1'b0, dvs_ff};
      rem_in = ge ? diff[DVS_BITS-1:0] : shifted[DVS_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
            rem_ff <= '0;
            quo_ff <= dividend;
            dvs_ff <= divisor;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[DVD_BITS-2:0], ge};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(DVD_BITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== src/mac_front.sv =====
// Front end: accepts request transactions, classifies them and queues them.
// Depends on mac_pkg.
module mac_front import mac_pkg::*; #(
   parameter int PRICE_BITS = PRICE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((PRICE_BITS+7)/8)*8-1:0]       req_tdata,
   input  logic [IN_USER_BITS-1:0]               req_tuser,
   output logic                                  q_valid,
   output cmd_ctrl_type                          q_ctrl,
   output logic [PRICE_BITS-1:0]                 q_price,
   input  logic                                  q_pop
);

   logic [PRICE_BITS-1:0] price_ff [2];
   cmd_ctrl_type          ctrl_ff [2];
   logic                  wr_ptr_ff;
   logic                  rd_ptr_ff;
   logic [1:0]            count_ff;
   logic                  push;
   logic                  pop;
   cmd_ctrl_type          ctrl_in;

   assign req_tready = count_ff != 2'd2;
   assign push = req_tvalid && req_tready;
   assign pop = q_pop && q_valid;

   always_comb begin
      ctrl_in.op = req_tuser[0] ? OP_DROP : OP_SAMPLE;
      ctrl_in.clear = req_tuser[1];
   end

   always_ff @(posedge clock) begin
      if (push) begin
         price_ff[wr_ptr_ff] <= req_tdata[PRICE_BITS-1:0];
         ctrl_ff[wr_ptr_ff] <= ctrl_in;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         if (push && !pop) count_ff <= count_ff + 2'd1;
         else if (pop && !push) count_ff <= count_ff - 2'd1;
      end
   end

   assign q_valid = count_ff != 2'd0;
   assign q_ctrl = ctrl_ff[rd_ptr_ff];
   assign q_price = price_ff[rd_ptr_ff];

endmodule

// ===== src/mac_back.sv =====
// Back end: sample ring, running window sums, averages, crossing detection
// and the result register. Depends on mac_pkg and mac_divider.
module mac_back import mac_pkg::*; #(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF,
   parameter int PRICE_BITS = PRICE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [CSR_ADDR_BITS-1:0]            csr_addr,
   input  logic [WIN_BITS-1:0]                 csr_wdata,
   input  logic                                q_valid,
   input  cmd_ctrl_type                        q_ctrl,
   input  logic [PRICE_BITS-1:0]               q_price,
   output logic                                q_pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((3*PRICE_BITS+7)/8)*8-1:0]   rsp_tdata,
   output logic [OUT_USER_BITS-1:0]            rsp_tuser
);

   localparam int P = PRICE_BITS;
   localparam int AW = $clog2(MAX_WINDOW);
   localparam int CW = $clog2(MAX_WINDOW + 1);
   localparam int CMPW = (CW > WIN_BITS) ? CW : WIN_BITS;
   localparam int SUM_BITS = P + CW;
   localparam int DVD_BITS = 2 * P;
   localparam int DVS_BITS = P + 1;
   localparam int OUT_DATA_BITS = ((3 * P + 7) / 8) * 8;
   localparam logic [CMPW-1:0] MAX_C = CMPW'(MAX_WINDOW);
   localparam logic [CMPW-1:0] ONE_C = CMPW'(1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_WINDOW);
   localparam logic [AW-1:0] LAST_POS = AW'(MAX_WINDOW - 1);
   localparam logic [P-1:0] PMAX = {P{1'b1}};
   localparam logic [P:0] PLIM = {1'b1, {P{1'b0}}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INC_ADDR,
      ST_INC_DATA,
      ST_SW_SETUP,
      ST_SW_ADDR,
      ST_SW_DATA,
      ST_DIV,
      ST_DIV_WAIT,
      ST_CROSS,
      ST_MUL,
      ST_XDIV,
      ST_XDIV_WAIT,
      ST_OUT
   } state_type;

   state_type state_ff;

   logic [P-1:0]          hist [MAX_WINDOW];
   logic [P-1:0]          rd_data_ff;
   logic                  mem_we, mem_re;
   logic [AW-1:0]         mem_waddr, mem_raddr;

   logic [WIN_BITS-1:0]   short_window_ff, long_window_ff;
   logic                  dirty_ff;
   logic [AW-1:0]         wp_ff, wp_old_ff, ptr_ff;
   logic [CW-1:0]         count_ff, cnt_old_ff, k_ff, n_ff;
   logic [SUM_BITS-1:0]   sum_s_ff, sum_l_ff, acc_ff;
   logic [P-1:0]          prev_s_ff, prev_l_ff, price_ff;
   logic [P-1:0]          avg_s_ff, avg_l_ff, cprice_ff;
   logic                  fill_s_ff, fill_l_ff;
   logic                  has_prev_ff, item_valid_ff, sel_ff, neg_ff;
   logic [1:0]            kind_ff;
   logic [P-1:0]          mag_d0_ff, mag_delta_ff;
   logic [P:0]            mag_den_ff;
   logic [DVD_BITS-1:0]   prod_ff;
   logic                  rsp_valid_ff;
   logic [OUT_DATA_BITS-1:0] rsp_data_ff;
   logic [OUT_USER_BITS-1:0] rsp_user_ff;

   logic [CW-1:0]         cnt_base;
   logic [AW-1:0]         wp_base;
   logic [WIN_BITS-1:0]   w_cur;
   logic [CMPW-1:0]       w_ext, cnt_new_ext, cnt_old_ext, wp_ext, addr_full;
   logic                  w_ok, inc_sub, fill_cur, div_cur;
   logic [AW-1:0]         inc_addr;
   logic [CW-1:0]         n_cur;
   logic [SUM_BITS-1:0]   sum_cur, inc_sum;
   logic signed [P:0]     d0, d1, delta;
   logic signed [P+1:0]   den;
   logic [P:0]            abs_d0, abs_delta;
   logic [P+1:0]          abs_den;
   logic                  neg_cur;
   logic [1:0]            kind_cur;
   logic [P:0]            qc;
   logic [P+1:0]          pos_sum;
   logic [P-1:0]          xprice;
   logic                  div_start, div_done;
   logic [DVD_BITS-1:0]   div_dvd, div_quo;
   logic [DVS_BITS-1:0]   div_dvs;
   logic                  out_load;

   always_comb begin
      cnt_base = q_ctrl.clear ? '0 : count_ff;
      wp_base = q_ctrl.clear ? '0 : wp_ff;
      w_cur = sel_ff ? long_window_ff : short_window_ff;
      w_ext = CMPW'(w_cur);
      cnt_new_ext = CMPW'(count_ff);
      cnt_old_ext = CMPW'(cnt_old_ff);
      wp_ext = CMPW'(wp_old_ff);
      w_ok = (w_ext != '0) && (w_ext <= MAX_C);
      inc_sub = w_ok && (cnt_old_ext >= w_ext);
      addr_full = (wp_ext >= w_ext) ? wp_ext - w_ext : wp_ext + MAX_C - w_ext;
      inc_addr = addr_full[AW-1:0];
      div_cur = (w_ext > ONE_C) && (w_ext <= MAX_C) && (w_ext <= cnt_new_ext);
      fill_cur = (w_ext == ONE_C) || div_cur;
      n_cur = !w_ok ? '0 : ((w_ext < cnt_new_ext) ? CW'(w_ext) : count_ff);
      sum_cur = sel_ff ? sum_l_ff : sum_s_ff;
      inc_sum = sum_cur + SUM_BITS'(price_ff)
              - (inc_sub ? SUM_BITS'(rd_data_ff) : SUM_BITS'(0));

      d0 = $signed({1'b0, prev_s_ff}) - $signed({1'b0, prev_l_ff});
      d1 = $signed({1'b0, avg_l_ff}) - $signed({1'b0, avg_s_ff});
      delta = $signed({1'b0, avg_s_ff}) - $signed({1'b0, prev_s_ff});
      den = {d0[P], d0} + {d1[P], d1};
      abs_d0 = d0[P] ? -d0 : d0;
      abs_delta = delta[P] ? -delta : delta;
      abs_den = den[P+1] ? -den : den;
      neg_cur = (delta[P] != d0[P]) != den[P+1];
      if (d0[P] && d1[P]) kind_cur = CROSS_UP;
      else if (!d0[P] && d0 != '0 && !d1[P] && d1 != '0) kind_cur = CROSS_DOWN;
      else kind_cur = CROSS_NONE;

      qc = (div_quo > DVD_BITS'(PLIM)) ? PLIM : div_quo[P:0];
      pos_sum = {1'b0, qc} + {2'b00, prev_s_ff};
      if (neg_ff) xprice = (qc >= {1'b0, prev_s_ff}) ? '0 : P'({1'b0, prev_s_ff} - qc);
      else xprice = (pos_sum > {2'b00, PMAX}) ? PMAX : pos_sum[P-1:0];
   end

   assign q_pop = (state_ff == ST_IDLE) && q_valid;
   assign mem_we = ((state_ff == ST_INC_DATA) && sel_ff) || (state_ff == ST_SW_SETUP);
   assign mem_waddr = wp_old_ff;
   assign mem_re = ((state_ff == ST_INC_ADDR) && inc_sub)
                || ((state_ff == ST_SW_ADDR) && (k_ff != n_ff));
   assign mem_raddr = (state_ff == ST_INC_ADDR) ? inc_addr : ptr_ff;

   always_ff @(posedge clock) begin
      if (mem_we) hist[mem_waddr] <= price_ff;
      if (mem_re) rd_data_ff <= hist[mem_raddr];
   end

   assign div_start = ((state_ff == ST_DIV) && div_cur) || (state_ff == ST_XDIV);
   assign div_dvd = (state_ff == ST_XDIV) ? prod_ff : DVD_BITS'(sum_cur);
   assign div_dvs = (state_ff == ST_XDIV) ? mag_den_ff : DVS_BITS'(w_cur);

   mac_divider #(
      .DVD_BITS(DVD_BITS),
      .DVS_BITS(DVS_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         short_window_ff <= SHORT_WINDOW_RST;
         long_window_ff <= LONG_WINDOW_RST;
         dirty_ff <= 1'b0;
         wp_ff <= '0;
         count_ff <= '0;
         sum_s_ff <= '0;
         sum_l_ff <= '0;
         prev_s_ff <= '0;
         prev_l_ff <= '0;
         rsp_valid_ff <= 1'b0;
         sel_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && !out_load) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  if (q_ctrl.clear) begin
                     sum_s_ff <= '0;
                     sum_l_ff <= '0;
                     prev_s_ff <= '0;
                     prev_l_ff <= '0;
                     dirty_ff <= 1'b0;
                  end
                  sel_ff <= 1'b0;
                  if (q_ctrl.op == OP_DROP) begin
                     if (q_ctrl.clear) begin
                        count_ff <= '0;
                        wp_ff <= '0;
                     end
                     item_valid_ff <= 1'b0;
                     state_ff <= ST_OUT;
                  end else begin
                     item_valid_ff <= 1'b1;
                     price_ff <= q_price;
                     has_prev_ff <= cnt_base != '0;
                     cnt_old_ff <= cnt_base;
                     wp_old_ff <= wp_base;
                     wp_ff <= (wp_base == LAST_POS) ? '0 : wp_base + 1'b1;
                     count_ff <= (cnt_base == MAX_CNT) ? MAX_CNT : cnt_base + 1'b1;
                     state_ff <= (dirty_ff && !q_ctrl.clear) ? ST_SW_SETUP : ST_INC_ADDR;
                  end
               end
            end
            ST_INC_ADDR: state_ff <= ST_INC_DATA;
            ST_INC_DATA: begin
               if (sel_ff) sum_l_ff <= inc_sum;
               else sum_s_ff <= inc_sum;
               sel_ff <= ~sel_ff;
               state_ff <= sel_ff ? ST_DIV : ST_INC_ADDR;
            end
            ST_SW_SETUP: begin
               n_ff <= n_cur;
               k_ff <= '0;
               acc_ff <= '0;
               ptr_ff <= wp_old_ff;
               state_ff <= ST_SW_ADDR;
            end
            ST_SW_ADDR: begin
               if (k_ff == n_ff) begin
                  if (sel_ff) sum_l_ff <= acc_ff;
                  else sum_s_ff <= acc_ff;
                  sel_ff <= ~sel_ff;
                  if (sel_ff) begin
                     dirty_ff <= 1'b0;
                     state_ff <= ST_DIV;
                  end else begin
                     state_ff <= ST_SW_SETUP;
                  end
               end else begin
                  ptr_ff <= (ptr_ff == '0) ? LAST_POS : ptr_ff - 1'b1;
                  k_ff <= k_ff + 1'b1;
                  state_ff <= ST_SW_DATA;
               end
            end
            ST_SW_DATA: begin
               acc_ff <= acc_ff + SUM_BITS'(rd_data_ff);
               state_ff <= ST_SW_ADDR;
            end
            ST_DIV: begin
               if (sel_ff) fill_l_ff <= fill_cur;
               else fill_s_ff <= fill_cur;
               if (div_cur) begin
                  state_ff <= ST_DIV_WAIT;
               end else begin
                  if (sel_ff) avg_l_ff <= price_ff;
                  else avg_s_ff <= price_ff;
                  sel_ff <= ~sel_ff;
                  state_ff <= sel_ff ? ST_CROSS : ST_DIV;
               end
            end
            ST_DIV_WAIT: begin
               if (div_done) begin
                  if (sel_ff) avg_l_ff <= div_quo[P-1:0];
                  else avg_s_ff <= div_quo[P-1:0];
                  sel_ff <= ~sel_ff;
                  state_ff <= sel_ff ? ST_CROSS : ST_DIV;
               end
            end
            ST_CROSS: begin
               kind_ff <= has_prev_ff ? kind_cur : CROSS_NONE;
               mag_d0_ff <= abs_d0[P-1:0];
               mag_delta_ff <= abs_delta[P-1:0];
               mag_den_ff <= abs_den[P:0];
               neg_ff <= neg_cur;
               if (!has_prev_ff) begin
                  cprice_ff <= '0;
                  state_ff <= ST_OUT;
               end else if (den == '0 || d0 == '0 || delta == '0) begin
                  cprice_ff <= prev_s_ff;
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               prod_ff <= mag_delta_ff * mag_d0_ff;
               state_ff <= ST_XDIV;
            end
            ST_XDIV: state_ff <= ST_XDIV_WAIT;
            ST_XDIV_WAIT: begin
               if (div_done) begin
                  cprice_ff <= xprice;
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_load) begin
                  rsp_valid_ff <= 1'b1;
                  if (item_valid_ff) begin
                     rsp_data_ff <= OUT_DATA_BITS'({cprice_ff, avg_l_ff, avg_s_ff});
                     rsp_user_ff <= {1'b1, kind_ff, fill_l_ff, fill_s_ff};
                     prev_s_ff <= avg_s_ff;
                     prev_l_ff <= avg_l_ff;
                  end else begin
                     rsp_data_ff <= '0;
                     rsp_user_ff <= '0;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         if (csr_we) begin
            unique case (csr_addr)
               CSR_SHORT_WINDOW: begin
                  short_window_ff <= csr_wdata;
                  dirty_ff <= 1'b1;
               end
               CSR_LONG_WINDOW: begin
                  long_window_ff <= csr_wdata;
                  dirty_ff <= 1'b1;
               end
               default: ;
            endcase
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

endmodule

// ===== src/moving_average_crossover.sv =====
// Dual moving average crossover: one price sample in, one result out.
// Request side: req_tdata holds the price; req_tuser bit 0 marks a no-data
// sample and bit 1 starts a new series (history cleared before the sample).
// Result side: rsp_tdata holds short average, long average and crossing
// price; rsp_tuser holds the filled flags, crossing kind and result_valid.
// Every request transaction yields exactly one result transaction, in order.
// Window lengths are written through the csr port while the block is idle;
// the user must keep to this, as the block itself does not enforce it.
// A sample makes up to three passes of the shared bit-serial divider (two
// averages and the crossing interpolation); a dropped sample makes none.
// The first sample after a window change, unless it starts a new series, adds
// two sweeps of min(window, stored) reads on the sample ring's one read port.
// A two-entry queue takes new requests while the back end works, and the
// result register holds its transaction while rsp_tready is low.
// Synchronous reset clears the queue, sums, counters and result valid flag
// and restores windows 10 and 20; the sample memory is not cleared.
// Depends on mac_pkg, mac_front, mac_back and mac_divider.
module moving_average_crossover import mac_pkg::*; #(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF,
   parameter int PRICE_BITS = PRICE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [CSR_ADDR_BITS-1:0]            csr_addr,
   input  logic [WIN_BITS-1:0]                 csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // price_sample
   input  logic [((PRICE_BITS+7)/8)*8-1:0]     req_tdata,
   // sample_invalid, series_start
   input  logic [IN_USER_BITS-1:0]             req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // short_average, long_average, cross_price
   output logic [((3*PRICE_BITS+7)/8)*8-1:0]   rsp_tdata,
   // short_filled, long_filled, cross_kind (2 bits), result_valid
   output logic [OUT_USER_BITS-1:0]            rsp_tuser
);

   logic                  q_valid;
   logic                  q_pop;
   cmd_ctrl_type          q_ctrl;
   logic [PRICE_BITS-1:0] q_price;

   mac_front #(
      .PRICE_BITS(PRICE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_ctrl     (q_ctrl),
      .q_price    (q_price),
      .q_pop      (q_pop)
   );

   mac_back #(
      .MAX_WINDOW(MAX_WINDOW),
      .PRICE_BITS(PRICE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .q_valid    (q_valid),
      .q_ctrl     (q_ctrl),
      .q_price    (q_price),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== src/mac_checker.sv =====
// Port-level checks for the moving average crossover, bound to the top level.
// Depends on mac_pkg.
module mac_checker import mac_pkg::*; #(
   parameter int PRICE_BITS = PRICE_BITS_DEF
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [((3*PRICE_BITS+7)/8)*8-1:0]   rsp_tdata,
   input logic [OUT_USER_BITS-1:0]            rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[4] |-> rsp_tdata == '0 && rsp_tuser[3:0] == '0)
      else $error("dropped sample gave nonzero fields");

   a_kind_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[3:2] == CROSS_NONE || rsp_tuser[3:2] == CROSS_UP
                     || rsp_tuser[3:2] == CROSS_DOWN)
      else $error("bad crossing kind");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind moving_average_crossover mac_checker #(
   .PRICE_BITS(PRICE_BITS)
) u_mac_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
